### hw/rtl/scbp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scbp_pkg
// Types, constants and helpers shared by the size class block pool.
// ----------------------------------------------------------------------------
package scbp_pkg;

   localparam int NUM_CLASSES = 8;
   localparam int CLASS_W     = 3;
   localparam int SIZE_W      = 16;
   localparam int ID_W        = 8;
   localparam int CSR_INDEX_W = 8;

   localparam int POOL_BLOCKS_DEF = 128;
   localparam int STACK_DEPTH_DEF = 16;

   localparam logic [SIZE_W-1:0] CLASS_RESET_SIZE [NUM_CLASSES] = '{
      16'd64, 16'd96, 16'd128, 16'd192, 16'd256, 16'd512, 16'd1024, 16'd4096
   };

   typedef enum logic {
      CMD_TAKE = 1'b0,
      CMD_PUT  = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_NO_FIT = 2'd1,
      STATUS_REJECT = 2'd2
   } status_type;

   typedef struct packed {
      logic              cmd;
      logic [SIZE_W-1:0] request_size;
      logic [ID_W-1:0]   block_id;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [ID_W-1:0]   given_id;
      logic [SIZE_W-1:0] given_capacity;
   } rsp_type;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [SIZE_W-1:0] cap;
   } entry_type;

   typedef struct packed {
      logic               pop;
      logic               push;
      status_type         status;
      logic [CLASS_W-1:0] cls;
   } dec_type;

   // blocks loaded into class c after reset, capped at the stack depth
   function automatic int fill_reset(input int pool, input int depth, input int c);
      int n;
      n = (pool - c + NUM_CLASSES - 1) >> CLASS_W;
      return (n < depth) ? n : depth;
   endfunction

endpackage

### hw/rtl/scbp_class_sel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scbp_class_sel
// Picks the class for a take or a put from the class sizes and stack levels.
// ----------------------------------------------------------------------------
module scbp_class_sel (
   input  scbp_pkg::req_type                                    item,
   input  logic [scbp_pkg::NUM_CLASSES-1:0][scbp_pkg::SIZE_W-1:0] sizes,
   input  logic [scbp_pkg::NUM_CLASSES-1:0]                     nonempty,
   input  logic [scbp_pkg::NUM_CLASSES-1:0]                     full,
   output scbp_pkg::dec_type                                    dec
);

   logic [scbp_pkg::SIZE_W-1:0]  want;
   logic [scbp_pkg::CLASS_W-1:0] fit_cls;
   logic                         any_fit;
   logic [scbp_pkg::CLASS_W-1:0] last_used;
   logic [scbp_pkg::CLASS_W-1:0] first_ge;
   logic                         any_ge;
   logic [scbp_pkg::SIZE_W-1:0]  fit_size;
   logic                         close_fit;

   assign want = item.request_size;

   always_comb begin
      fit_cls   = '0;
      any_fit   = 1'b0;
      first_ge  = '0;
      any_ge    = 1'b0;
      last_used = '0;
      for (int c = scbp_pkg::NUM_CLASSES - 1; c >= 0; c--) begin
         if (nonempty[c] && sizes[c] >= want) begin
            fit_cls = scbp_pkg::CLASS_W'(c);
            any_fit = 1'b1;
         end
         if (sizes[c] >= want) begin
            first_ge = scbp_pkg::CLASS_W'(c);
            any_ge   = 1'b1;
         end
      end
      for (int c = 0; c < scbp_pkg::NUM_CLASSES; c++) begin
         if (nonempty[c]) begin
            last_used = scbp_pkg::CLASS_W'(c);
         end
      end
   end

   assign fit_size  = sizes[fit_cls];
   assign close_fit = (fit_size - want) <= (want >> 2);

   always_comb begin
      dec.pop    = 1'b0;
      dec.push   = 1'b0;
      dec.status = scbp_pkg::STATUS_OK;
      dec.cls    = '0;
      if (item.cmd == scbp_pkg::CMD_TAKE) begin
         if (!any_fit) begin
            dec.status = scbp_pkg::STATUS_NO_FIT;
         end else begin
            dec.pop = 1'b1;
            dec.cls = close_fit ? fit_cls : last_used;
         end
      end else begin
         dec.cls = first_ge;
         if (!any_ge || full[first_ge]) begin
            dec.status = scbp_pkg::STATUS_REJECT;
         end else begin
            dec.push = 1'b1;
         end
      end
   end

endmodule

### hw/rtl/scbp_stack_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scbp_stack_mem
// Block stack storage with registered read and the load sweep after reset.
// ----------------------------------------------------------------------------
module scbp_stack_mem #(
   parameter int POOL_BLOCKS = scbp_pkg::POOL_BLOCKS_DEF,
   parameter int STACK_DEPTH = scbp_pkg::STACK_DEPTH_DEF,
   parameter int ADDR_W      = 7
) (
   input  logic                clock,
   input  logic                reset,
   output logic                busy,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  scbp_pkg::entry_type wr_entry,
   input  logic                rd_en,
   input  logic [ADDR_W-1:0]   rd_addr,
   output scbp_pkg::entry_type rd_entry
);

   localparam int MEM_DEPTH = 1 << ADDR_W;
   localparam int SLOT_W    = ADDR_W - scbp_pkg::CLASS_W;
   localparam int STACK_ALL = scbp_pkg::NUM_CLASSES * STACK_DEPTH;
   localparam int INIT_LEN  = (POOL_BLOCKS < STACK_ALL) ? POOL_BLOCKS : STACK_ALL;
   localparam int POS_W     = $clog2(INIT_LEN);

   scbp_pkg::entry_type mem [MEM_DEPTH];

   logic                        busy_ff;
   logic                        busy_in;
   logic [POS_W-1:0]            pos_ff;
   logic [POS_W-1:0]            pos_in;
   logic [scbp_pkg::CLASS_W-1:0] init_cls;
   logic [SLOT_W-1:0]           init_slot;
   logic                        we;
   logic [ADDR_W-1:0]           wa;
   scbp_pkg::entry_type         wd;

   assign init_cls  = pos_ff[scbp_pkg::CLASS_W-1:0];
   assign init_slot = SLOT_W'(pos_ff >> scbp_pkg::CLASS_W);

   always_comb begin
      pos_in  = pos_ff;
      busy_in = busy_ff;
      if (busy_ff) begin
         pos_in = pos_ff + POS_W'(1);
         if (pos_ff == POS_W'(INIT_LEN - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_comb begin
      if (busy_ff) begin
         we     = 1'b1;
         wa     = {init_cls, init_slot};
         wd.id  = scbp_pkg::ID_W'(pos_ff) + scbp_pkg::ID_W'(1);
         wd.cap = scbp_pkg::CLASS_RESET_SIZE[init_cls];
      end else begin
         we = wr_en;
         wa = wr_addr;
         wd = wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         pos_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         pos_ff  <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_entry <= mem[rd_addr];
      end
   end

   assign busy = busy_ff;

endmodule

### hw/rtl/size_class_block_pool.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// size_class_block_pool
// Segregated-fit pool of free blocks kept as LIFO stacks in eight size classes.
// ----------------------------------------------------------------------------
//  channel | ports                                  | handshake
//  --------+----------------------------------------+---------------------------
//  request | start, busy, req_data                  | beat when start & !busy
//  result  | rsp_valid, rsp_data                    | one-cycle strobe, no stall
//  config  | csr_valid, csr_ready, csr_index, csr_wdata | beat when valid & ready
//
//  One beat per cycle while busy is low; the request register holds the accepted beat.
//  Class choice, level update and stack read follow in the same cycle; the result is registered.
//  After reset, busy stays high while the stacks are loaded with min(POOL_BLOCKS,
//  8 * STACK_DEPTH) blocks; config beats are taken meanwhile.
//  The receiver cannot stall; csr_ready is always high.
// ----------------------------------------------------------------------------
module size_class_block_pool #(
   parameter int POOL_BLOCKS = scbp_pkg::POOL_BLOCKS_DEF,
   parameter int STACK_DEPTH = scbp_pkg::STACK_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  scbp_pkg::req_type                req_data,
   output logic                             rsp_valid,
   output scbp_pkg::rsp_type                rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [scbp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [scbp_pkg::SIZE_W-1:0]      csr_wdata
);

   localparam int FILL_W = $clog2(STACK_DEPTH + 1);
   localparam int SLOT_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int ADDR_W = scbp_pkg::CLASS_W + SLOT_W;

   logic [scbp_pkg::NUM_CLASSES-1:0][scbp_pkg::SIZE_W-1:0] size_ff;
   logic [FILL_W-1:0]            fill_ff [scbp_pkg::NUM_CLASSES];
   logic [scbp_pkg::NUM_CLASSES-1:0] nonempty;
   logic [scbp_pkg::NUM_CLASSES-1:0] full;

   logic                         req_valid_ff;
   scbp_pkg::req_type            req_ff;
   scbp_pkg::dec_type            dec;
   logic                         do_pop;
   logic                         do_push;
   logic [FILL_W-1:0]            cls_fill;
   logic [FILL_W-1:0]            cls_fill_in;
   logic [SLOT_W-1:0]            push_slot;
   logic [SLOT_W-1:0]            pop_slot;
   scbp_pkg::entry_type          wr_entry;
   scbp_pkg::entry_type          rd_entry;

   logic                         rsp_valid_ff;
   logic                         rsp_pop_ff;
   logic [1:0]                   rsp_status_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < scbp_pkg::NUM_CLASSES; c++) begin
            size_ff[c] <= scbp_pkg::CLASS_RESET_SIZE[c];
         end
      end else if (csr_valid && csr_index < scbp_pkg::CSR_INDEX_W'(scbp_pkg::NUM_CLASSES)) begin
         size_ff[csr_index[scbp_pkg::CLASS_W-1:0]] <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         req_ff <= req_data;
      end
   end

   always_comb begin
      for (int c = 0; c < scbp_pkg::NUM_CLASSES; c++) begin
         nonempty[c] = fill_ff[c] != '0;
         full[c]     = fill_ff[c] >= FILL_W'(STACK_DEPTH);
      end
   end

   scbp_class_sel u_class_sel (
      .item     (req_ff),
      .sizes    (size_ff),
      .nonempty (nonempty),
      .full     (full),
      .dec      (dec)
   );

   assign do_pop    = req_valid_ff && dec.pop;
   assign do_push   = req_valid_ff && dec.push;
   assign cls_fill  = fill_ff[dec.cls];
   assign push_slot = cls_fill[SLOT_W-1:0];
   assign pop_slot  = SLOT_W'(cls_fill - FILL_W'(1));

   always_comb begin
      cls_fill_in = cls_fill;
      if (do_pop) begin
         cls_fill_in = cls_fill - FILL_W'(1);
      end else if (do_push) begin
         cls_fill_in = cls_fill + FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < scbp_pkg::NUM_CLASSES; c++) begin
            fill_ff[c] <= FILL_W'(scbp_pkg::fill_reset(POOL_BLOCKS, STACK_DEPTH, c));
         end
      end else if (do_pop || do_push) begin
         fill_ff[dec.cls] <= cls_fill_in;
      end
   end

   assign wr_entry.id  = req_ff.block_id;
   assign wr_entry.cap = req_ff.request_size;

   scbp_stack_mem #(
      .POOL_BLOCKS (POOL_BLOCKS),
      .STACK_DEPTH (STACK_DEPTH),
      .ADDR_W      (ADDR_W)
   ) u_stack_mem (
      .clock    (clock),
      .reset    (reset),
      .busy     (busy),
      .wr_en    (do_push),
      .wr_addr  ({dec.cls, push_slot}),
      .wr_entry (wr_entry),
      .rd_en    (do_pop),
      .rd_addr  ({dec.cls, pop_slot}),
      .rd_entry (rd_entry)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_pop_ff    <= do_pop;
      rsp_status_ff <= dec.status;
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_data.status         = rsp_status_ff;
   assign rsp_data.given_id       = rsp_pop_ff ? rd_entry.id : '0;
   assign rsp_data.given_capacity = rsp_pop_ff ? rd_entry.cap : '0;

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_valid)
      else $error("accepted beat gave no result");

   a_load_once: assert property (@(posedge clock) disable iff (reset)
      !busy |=> !busy)
      else $error("stack load restarted");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      do_pop |-> cls_fill != '0)
      else $error("pop from empty class");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      do_push |-> cls_fill < FILL_W'(STACK_DEPTH))
      else $error("push onto full class");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != scbp_pkg::STATUS_OK)
         |-> (rsp_data.given_id == '0 && rsp_data.given_capacity == '0))
      else $error("failed beat carries a block");

endmodule
